### src/fit_policy_bitmap_allocator_assert.svh
`ifndef FIT_POLICY_BITMAP_ALLOCATOR_ASSERT_SVH
`define FIT_POLICY_BITMAP_ALLOCATOR_ASSERT_SVH

// checked only out of reset
`define FPBA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every edge
`define FPBA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### src/fpba_pkg.sv
package fpba_pkg;

  localparam int UNITS = 65536;
  localparam int UW = $clog2(UNITS);
  localparam int WB = 32;
  localparam int WORDS = UNITS / WB;
  localparam int WAW = $clog2(WORDS);
  localparam int FAIL_MAX = 65535;

  typedef enum logic [1:0] {
    CMD_ALLOC   = 2'd0,
    CMD_COMPACT = 2'd1,
    CMD_LOAD    = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_ALLOC   = 2'd0,
    ST_FAIL    = 2'd1,
    ST_COMPACT = 2'd2,
    ST_LOADED  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    POL_FIRST = 2'd0,
    POL_NEXT  = 2'd1,
    POL_BEST  = 2'd2,
    POL_WORST = 2'd3
  } policy_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_LD_RD, S_LD_WR, S_AL_RD, S_AL_SCAN, S_AL_END,
    S_MK_RD, S_MK_WR, S_CP_RD, S_CP_CNT, S_CP_WR, S_RESP
  } state_t;

  typedef struct packed {
    logic clr;
    logic capture;
    logic ld_rd;
    logic ld_wr;
    logic al_init;
    logic al_rd;
    logic al_step;
    logic mk_pick;
    logic mk_rd;
    logic mk_wr;
    logic cp_rd;
    logic cp_cnt;
    logic cp_wr;
    logic res_ld;
    logic res_al;
    logic res_fail;
    logic res_cp;
  } ctrl_t;

  typedef struct packed {
    logic waddr_last;
    logic in_size_zero;
    logic ff_hit;
    logic scan_last;
    logic fetch_next;
    logic have;
    logic mk_last;
  } stat_t;

endpackage

### src/fpba_if.sv
interface fpba_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [16:0] request_size;
  logic [31:0] request_tag;
  logic [15:0] unit_index;
  logic        unit_used;

  modport source (output valid, command, request_size, request_tag, unit_index, unit_used,
                  input ready);
  modport sink (input valid, command, request_size, request_tag, unit_index, unit_used,
                output ready);
endinterface

interface fpba_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [15:0] start_unit;
  logic [31:0] echo_tag;
  logic [16:0] echo_size;
  logic [15:0] fail_count;

  modport source (output valid, status, start_unit, echo_tag, echo_size, fail_count,
                  input ready);
  modport sink (input valid, status, start_unit, echo_tag, echo_size, fail_count,
                output ready);
endinterface

### src/fpba_ctrl.sv
module fpba_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [1:0]        in_command,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  fpba_pkg::stat_t   stat,
  output fpba_pkg::ctrl_t   ctrl
);

  fpba_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fpba_pkg::S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctrl = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    unique case (state)
      fpba_pkg::S_CLEAR: begin
        ctrl.clr = 1'b1;
        if (stat.waddr_last) state_next = fpba_pkg::S_IDLE;
      end
      fpba_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctrl.capture = 1'b1;
          unique case (fpba_pkg::cmd_t'(in_command))
            fpba_pkg::CMD_ALLOC: begin
              if (stat.in_size_zero) begin
                ctrl.res_fail = 1'b1;
                state_next = fpba_pkg::S_RESP;
              end else begin
                ctrl.al_init = 1'b1;
                state_next = fpba_pkg::S_AL_RD;
              end
            end
            fpba_pkg::CMD_COMPACT: state_next = fpba_pkg::S_CP_RD;
            fpba_pkg::CMD_LOAD: state_next = fpba_pkg::S_LD_RD;
            fpba_pkg::CMD_NONE: begin
              ctrl.res_ld = 1'b1;
              state_next = fpba_pkg::S_RESP;
            end
          endcase
        end
      end
      fpba_pkg::S_LD_RD: begin
        ctrl.ld_rd = 1'b1;
        state_next = fpba_pkg::S_LD_WR;
      end
      fpba_pkg::S_LD_WR: begin
        ctrl.ld_wr = 1'b1;
        ctrl.res_ld = 1'b1;
        state_next = fpba_pkg::S_RESP;
      end
      fpba_pkg::S_AL_RD: begin
        ctrl.al_rd = 1'b1;
        state_next = fpba_pkg::S_AL_SCAN;
      end
      fpba_pkg::S_AL_SCAN: begin
        ctrl.al_step = 1'b1;
        priority if (stat.ff_hit) state_next = fpba_pkg::S_MK_RD;
        else if (stat.scan_last) state_next = fpba_pkg::S_AL_END;
        else if (stat.fetch_next) state_next = fpba_pkg::S_AL_RD;
        else state_next = fpba_pkg::S_AL_SCAN;
      end
      fpba_pkg::S_AL_END: begin
        if (stat.have) begin
          ctrl.mk_pick = 1'b1;
          state_next = fpba_pkg::S_MK_RD;
        end else begin
          ctrl.res_fail = 1'b1;
          state_next = fpba_pkg::S_RESP;
        end
      end
      fpba_pkg::S_MK_RD: begin
        ctrl.mk_rd = 1'b1;
        state_next = fpba_pkg::S_MK_WR;
      end
      fpba_pkg::S_MK_WR: begin
        ctrl.mk_wr = 1'b1;
        if (stat.mk_last) begin
          ctrl.res_al = 1'b1;
          state_next = fpba_pkg::S_RESP;
        end else begin
          state_next = fpba_pkg::S_MK_RD;
        end
      end
      fpba_pkg::S_CP_RD: begin
        ctrl.cp_rd = 1'b1;
        state_next = fpba_pkg::S_CP_CNT;
      end
      fpba_pkg::S_CP_CNT: begin
        ctrl.cp_cnt = 1'b1;
        state_next = stat.waddr_last ? fpba_pkg::S_CP_WR : fpba_pkg::S_CP_RD;
      end
      fpba_pkg::S_CP_WR: begin
        ctrl.cp_wr = 1'b1;
        if (stat.waddr_last) begin
          ctrl.res_cp = 1'b1;
          state_next = fpba_pkg::S_RESP;
        end
      end
      fpba_pkg::S_RESP: begin
        out_valid = 1'b1;
        if (out_ready) state_next = fpba_pkg::S_IDLE;
      end
      default: state_next = fpba_pkg::S_IDLE;
    endcase
  end

endmodule

### src/fpba_dp.sv
module fpba_dp (
  input  logic              clk,
  input  logic              rst,
  input  fpba_pkg::ctrl_t   ctrl,
  output fpba_pkg::stat_t   stat,
  input  logic              cfg_wr_en,
  input  logic [1:0]        cfg_wr_data,
  input  logic [1:0]        in_command,
  input  logic [16:0]       in_size,
  input  logic [31:0]       in_tag,
  input  logic [15:0]       in_index,
  input  logic              in_used,
  output logic [1:0]        out_status,
  output logic [15:0]       out_start,
  output logic [31:0]       out_tag,
  output logic [16:0]       out_size,
  output logic [15:0]       out_fails
);

  localparam int UW = fpba_pkg::UW;
  localparam int WAW = fpba_pkg::WAW;
  localparam int WB = fpba_pkg::WB;

  logic [WB-1:0]  mem [fpba_pkg::WORDS];
  logic [WB-1:0]  rd_data;
  logic           rd_en, wr_en;
  logic [WAW-1:0] rd_addr, wr_addr;
  logic [WB-1:0]  wr_data;

  logic [1:0]     policy;
  logic [1:0]     req_cmd;
  logic [16:0]    req_size;
  logic [31:0]    req_tag;
  logic [15:0]    req_index;
  logic           req_used;

  logic [WAW-1:0] waddr;
  logic [UW-1:0]  pos, it, run_start, pick_start, next_start, mk_cur, res_start;
  logic [UW:0]    run_len, pick_len, mk_rem, cnt;
  logic           have;
  logic [15:0]    fails;
  logic [1:0]     res_status;

  logic           bit_free, close, fit, ff_hit, better;
  logic [UW:0]    rl_new;
  logic [UW-1:0]  rs_new;
  logic [4:0]     lo;
  logic [5:0]     room, span;
  logic [WB-1:0]  mk_mask, span_ones;
  logic [UW:0]    base;
  logic [4:0]     part;
  logic [WB-1:0]  cp_word, ld_word;
  logic           ld_ok;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data <= mem[rd_addr];
  end

  // scan step
  always_comb begin
    bit_free = !rd_data[pos[4:0]];
    rl_new = bit_free ? run_len + 1'b1 : run_len;
    rs_new = (bit_free && run_len == '0) ? pos : run_start;
    close = !bit_free || (pos == UW'(fpba_pkg::UNITS - 1)) ||
            (it == UW'(fpba_pkg::UNITS - 1));
    fit = close && (32'(rl_new) >= 32'(req_size));
    ff_hit = fit && (policy == fpba_pkg::POL_FIRST || policy == fpba_pkg::POL_NEXT);
    better = !have || (policy == fpba_pkg::POL_BEST && rl_new < pick_len) ||
             (policy == fpba_pkg::POL_WORST && rl_new > pick_len);
  end

  // mark mask
  always_comb begin
    lo = mk_cur[4:0];
    room = 6'd32 - {1'b0, lo};
    span = (mk_rem < (UW+1)'(room)) ? mk_rem[5:0] : room;
    span_ones = (span == 6'd32) ? '1 : ((WB'(1) << span[4:0]) - WB'(1));
    mk_mask = span_ones << lo;
  end

  // compact word
  always_comb begin
    base = {1'b0, waddr, 5'b0};
    part = 5'(cnt - base);
    if (cnt >= base + (UW+1)'(WB)) cp_word = '1;
    else if (cnt <= base) cp_word = '0;
    else cp_word = (WB'(1) << part) - WB'(1);
  end

  always_comb begin
    ld_ok = (req_cmd == fpba_pkg::CMD_LOAD) && (32'(req_index) < 32'(fpba_pkg::UNITS));
    ld_word = rd_data;
    ld_word[req_index[4:0]] = req_used;
  end

  always_comb begin
    rd_en = ctrl.ld_rd || ctrl.al_rd || ctrl.mk_rd || ctrl.cp_rd;
    priority if (ctrl.ld_rd) rd_addr = WAW'(32'(req_index) >> 5);
    else if (ctrl.al_rd) rd_addr = pos[UW-1:5];
    else if (ctrl.mk_rd) rd_addr = mk_cur[UW-1:5];
    else rd_addr = waddr;
    wr_en = ctrl.clr || ctrl.cp_wr || ctrl.mk_wr || (ctrl.ld_wr && ld_ok);
    priority if (ctrl.mk_wr) begin
      wr_addr = mk_cur[UW-1:5];
      wr_data = rd_data | mk_mask;
    end else if (ctrl.ld_wr) begin
      wr_addr = WAW'(32'(req_index) >> 5);
      wr_data = ld_word;
    end else if (ctrl.cp_wr) begin
      wr_addr = waddr;
      wr_data = cp_word;
    end else begin
      wr_addr = waddr;
      wr_data = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      waddr <= '0;
      policy <= fpba_pkg::POL_FIRST;
      next_start <= '0;
      fails <= '0;
    end else begin
      if (cfg_wr_en) policy <= cfg_wr_data;
      if (ctrl.clr || ctrl.cp_cnt || ctrl.cp_wr) waddr <= waddr + 1'b1;
      if (ctrl.al_step && ff_hit) next_start <= UW'(32'(rs_new) + 32'(req_size));
      if (ctrl.res_fail && fails != 16'(fpba_pkg::FAIL_MAX)) fails <= fails + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.capture) begin
      req_cmd <= in_command;
      req_size <= in_size;
      req_tag <= in_tag;
      req_index <= in_index;
      req_used <= in_used;
      cnt <= '0;
    end
    if (ctrl.al_init) begin
      pos <= (policy == fpba_pkg::POL_NEXT) ? next_start : '0;
      it <= '0;
      run_len <= '0;
      have <= 1'b0;
    end
    if (ctrl.al_step) begin
      pos <= pos + 1'b1;
      it <= it + 1'b1;
      run_start <= rs_new;
      run_len <= close ? '0 : rl_new;
      if (fit && better) begin
        have <= 1'b1;
        pick_len <= rl_new;
        pick_start <= rs_new;
      end
      if (ff_hit) begin
        mk_cur <= rs_new;
        mk_rem <= (UW+1)'(req_size);
        res_start <= rs_new;
      end
    end
    if (ctrl.mk_pick) begin
      mk_cur <= pick_start;
      mk_rem <= (UW+1)'(req_size);
      res_start <= pick_start;
    end
    if (ctrl.mk_wr) begin
      mk_cur <= mk_cur + UW'(span);
      mk_rem <= mk_rem - (UW+1)'(span);
    end
    if (ctrl.cp_cnt) cnt <= cnt + (UW+1)'($countones(rd_data));
    if (ctrl.res_al) res_status <= fpba_pkg::ST_ALLOC;
    if (ctrl.res_fail) begin
      res_status <= fpba_pkg::ST_FAIL;
      res_start <= '0;
    end
    if (ctrl.res_cp) begin
      res_status <= fpba_pkg::ST_COMPACT;
      res_start <= '0;
    end
    if (ctrl.res_ld) begin
      res_status <= fpba_pkg::ST_LOADED;
      res_start <= '0;
    end
  end

  always_comb begin
    stat.waddr_last = (waddr == '1);
    stat.in_size_zero = (in_size == '0);
    stat.ff_hit = ff_hit;
    stat.scan_last = (it == UW'(fpba_pkg::UNITS - 1));
    stat.fetch_next = (pos[4:0] == 5'd31);
    stat.have = have;
    stat.mk_last = (mk_rem == (UW+1)'(span));
  end

  assign out_status = res_status;
  assign out_start = 16'(res_start);
  assign out_tag = req_tag;
  assign out_size = req_size;
  assign out_fails = fails;

endmodule

### src/fit_policy_bitmap_allocator.sv
// channel  dir  payload                                                  transfer
// req      in   command, request_size, request_tag, unit_index, unit_used valid & ready
// rsp      out  status, start_unit, echo_tag, echo_size, fail_count       valid & ready
// cfg      in   fit_policy (cfg_wr_data)                                  cfg_wr_en
//
// one request at a time; the map is a 2048 x 32 memory with one read and one write port
// allocate: reads each word and tests each unit scanned (up to 65536), then reads and
//   writes each word of the chosen run; compact: counts then rewrites every word
// load: reads then writes one word; zero-size allocate and no-op command respond directly
// after reset a clearing pass over all 2048 words runs before the first request transfer
// a result waiting on rsp ready holds off the next request
`include "fit_policy_bitmap_allocator_assert.svh"

module fit_policy_bitmap_allocator (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wr_en,
  input  logic [1:0] cfg_wr_data,
  fpba_req_if.sink   req,
  fpba_rsp_if.source rsp
);

  fpba_pkg::ctrl_t ctrl;
  fpba_pkg::stat_t stat;

  fpba_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (req.valid),
    .in_command (req.command),
    .in_ready   (req.ready),
    .out_valid  (rsp.valid),
    .out_ready  (rsp.ready),
    .stat       (stat),
    .ctrl       (ctrl)
  );

  fpba_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .ctrl        (ctrl),
    .stat        (stat),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_command  (req.command),
    .in_size     (req.request_size),
    .in_tag      (req.request_tag),
    .in_index    (req.unit_index),
    .in_used     (req.unit_used),
    .out_status  (rsp.status),
    .out_start   (rsp.start_unit),
    .out_tag     (rsp.echo_tag),
    .out_size    (rsp.echo_size),
    .out_fails   (rsp.fail_count)
  );

  `FPBA_ASSERT_ALWAYS(a_one_at_a_time, !(rsp.valid && req.ready), "result pending while ready")
  `FPBA_ASSERT(a_fails_monotonic, rsp.fail_count >= $past(rsp.fail_count), "fail count fell")
  `FPBA_ASSERT(a_run_in_map, (rsp.valid && rsp.status == fpba_pkg::ST_ALLOC) |-> (32'(rsp.start_unit) + 32'(rsp.echo_size) <= 32'(fpba_pkg::UNITS)), "run past end")

endmodule

### sim/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import fpba_pkg::*;

  typedef struct {
    status_t     st;
    logic [15:0] start;
    logic [31:0] tag;
    logic [16:0] size;
    logic [15:0] fc;
  } result_t;

  typedef struct {
    policy_t     pol;
    cmd_t        cmd;
    logic [16:0] size;
    logic [31:0] tag;
    logic [15:0] idx;
    logic        used;
    bit          known;
    status_t     st;
    logic [15:0] start;
    logic [15:0] fc;
  } row_t;

  logic clk = 0;
  logic rst = 1;
  logic       cfg_wr_en = 0;
  logic [1:0] cfg_wr_data = '0;

  fpba_req_if req_ch();
  fpba_rsp_if rsp_ch();

  fit_policy_bitmap_allocator dut (
    .clk(clk), .rst(rst), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .req(req_ch), .rsp(rsp_ch)
  );

  always #4 clk = ~clk;

  // allocator state mirror
  bit          occ_map [UNITS];
  int unsigned next_pos;
  int unsigned fails_seen;
  policy_t     cur_policy;

  result_t pending_results[$];
  int errors, n_alloc, n_fail, n_compact, n_load;
  bit hold_off_req;
  bit cur_known;
  status_t cur_st;
  logic [15:0] cur_start, cur_fc;

  function automatic result_t predict_result(cmd_t c, logic [16:0] sz, logic [31:0] tag,
                                             logic [15:0] idx, logic used);
    result_t r;
    int unsigned pos, run_len, run_start, pick_len, pick_start, cnt;
    bit have, free_u, done;
    r.st = ST_LOADED; r.start = '0; r.tag = tag; r.size = sz;
    have = 0; done = 0; run_len = 0; run_start = 0; pick_len = 0; pick_start = 0;
    if (c == CMD_ALLOC) begin
      pos = (cur_policy == POL_NEXT) ? next_pos : 0;
      if (sz != 0) begin
        for (int it = 0; it < UNITS && !done; it++) begin
          free_u = !occ_map[pos];
          if (free_u) begin
            if (run_len == 0) run_start = pos;
            run_len++;
          end
          if (!free_u || pos == UNITS - 1 || it == UNITS - 1) begin
            if (run_len >= sz) begin
              if (cur_policy == POL_FIRST || cur_policy == POL_NEXT) begin
                have = 1; pick_start = run_start; done = 1;
                next_pos = (run_start + sz) % UNITS;
              end else if (!have || (cur_policy == POL_BEST && run_len < pick_len) ||
                           (cur_policy == POL_WORST && run_len > pick_len)) begin
                have = 1; pick_len = run_len; pick_start = run_start;
              end
            end
            run_len = 0;
          end
          pos = (pos + 1 == UNITS) ? 0 : pos + 1;
        end
      end
      if (have) begin
        for (int i = 0; i < sz; i++) occ_map[pick_start + i] = 1;
        r.st = ST_ALLOC; r.start = pick_start[15:0];
      end else begin
        r.st = ST_FAIL;
        if (fails_seen < FAIL_MAX) fails_seen++;
      end
    end else if (c == CMD_COMPACT) begin
      cnt = 0;
      for (int u = 0; u < UNITS; u++) if (occ_map[u]) cnt++;
      for (int u = 0; u < UNITS; u++) occ_map[u] = (u < cnt);
      r.st = ST_COMPACT;
    end else if (c == CMD_LOAD) begin
      occ_map[idx] = used;
    end
    r.fc = fails_seen[15:0];
    return r;
  endfunction

  // request transfers feed the mirror, response transfers are checked
  always @(posedge clk) begin
    result_t r, e;
    if (!rst && req_ch.valid && req_ch.ready) begin
      r = predict_result(cmd_t'(req_ch.command), req_ch.request_size, req_ch.request_tag,
                         req_ch.unit_index, req_ch.unit_used);
      if (cur_known) begin
        r.st = cur_st; r.start = cur_start; r.fc = cur_fc;
      end
      pending_results.push_back(r);
    end
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result status %0d", $time, rsp_ch.status);
      end else begin
        e = pending_results.pop_front();
        case (e.st)
          ST_ALLOC:   n_alloc++;
          ST_FAIL:    n_fail++;
          ST_COMPACT: n_compact++;
          default:    n_load++;
        endcase
        if (rsp_ch.status !== e.st || rsp_ch.start_unit !== e.start ||
            rsp_ch.echo_tag !== e.tag || rsp_ch.echo_size !== e.size ||
            rsp_ch.fail_count !== e.fc) begin
          errors++;
          $display("%0t: mismatch expected st=%0d start=%0d tag=%h size=%0d fc=%0d",
                   $time, e.st, e.start, e.tag, e.size, e.fc);
          $display("%0t:          actual   st=%0d start=%0d tag=%h size=%0d fc=%0d",
                   $time, rsp_ch.status, rsp_ch.start_unit, rsp_ch.echo_tag,
                   rsp_ch.echo_size, rsp_ch.fail_count);
        end
      end
    end
  end

  // receiver stall pattern
  initial begin
    int mode;
    rsp_ch.ready = 0;
    forever begin
      mode = $urandom_range(0, 2);
      repeat ($urandom_range(16, 96)) begin
        @(negedge clk);
        if (hold_off_req) begin
          rsp_ch.ready <= 0;
          repeat (3000) @(negedge clk);
          hold_off_req = 0;
        end
        case (mode)
          0:       rsp_ch.ready <= 1;
          1:       rsp_ch.ready <= $urandom_range(0, 1);
          default: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  task automatic drain();
    req_ch.valid <= 0;
    do @(negedge clk); while (pending_results.size() != 0);
  endtask

  task automatic set_policy(policy_t p);
    drain();
    cfg_wr_en <= 1;
    cfg_wr_data <= p;
    cur_policy = p;
    @(negedge clk);
    cfg_wr_en <= 0;
  endtask

  // called at a falling edge; returns at the falling edge after the transfer
  task automatic send_item(row_t r);
    cur_known = r.known; cur_st = r.st; cur_start = r.start; cur_fc = r.fc;
    req_ch.valid <= 1;
    req_ch.command <= r.cmd;
    req_ch.request_size <= r.size;
    req_ch.request_tag <= r.tag;
    req_ch.unit_index <= r.idx;
    req_ch.unit_used <= r.used;
    do @(posedge clk); while (!req_ch.ready);
    @(negedge clk);
  endtask

  function automatic row_t random_row();
    row_t r;
    int k;
    r.pol = cur_policy; r.known = 0; r.st = ST_ALLOC; r.start = '0; r.fc = '0;
    r.tag = $urandom();
    r.idx = $urandom_range(0, 1023);
    if ($urandom_range(0, 3) == 0) r.idx = $urandom();
    r.used = $urandom_range(0, 1);
    r.size = $urandom_range(1, 32);
    k = $urandom_range(0, 99);
    if (k < 45) r.cmd = CMD_LOAD;
    else if (k < 92) r.cmd = CMD_ALLOC;
    else if (k < 96) r.cmd = CMD_COMPACT;
    else r.cmd = CMD_NONE;
    k = $urandom_range(0, 99);
    if (k < 4) r.size = $urandom_range(1024, 65536);
    else if (k < 6) r.size = $urandom_range(65537, 131071);
    else if (k < 8) r.size = 0;
    return r;
  endfunction

  row_t directed [$] = '{
    '{POL_FIRST, CMD_ALLOC,   17'd0,      32'hffffffff, 16'd0,     1'b0, 1, ST_FAIL,    0, 1},
    '{POL_FIRST, CMD_ALLOC,   17'h1ffff,  32'h00000000, 16'hffff,  1'b1, 1, ST_FAIL,    0, 2},
    '{POL_BEST,  CMD_ALLOC,   17'd65536,  32'h5a5a5a5a, 16'd0,     1'b0, 1, ST_ALLOC,   0, 2},
    '{POL_BEST,  CMD_ALLOC,   17'd1,      32'ha5a5a5a5, 16'd0,     1'b0, 1, ST_FAIL,    0, 3},
    '{POL_BEST,  CMD_LOAD,    17'd1,      32'h1,        16'hffff,  1'b0, 1, ST_LOADED,  0, 3},
    '{POL_BEST,  CMD_NONE,    17'd9,      32'h2,        16'd3,     1'b0, 1, ST_LOADED,  0, 3},
    '{POL_BEST,  CMD_LOAD,    17'd1,      32'h3,        16'd0,     1'b0, 0, ST_LOADED,  0, 0},
    '{POL_BEST,  CMD_LOAD,    17'd1,      32'h4,        16'd10,    1'b0, 0, ST_LOADED,  0, 0},
    '{POL_BEST,  CMD_LOAD,    17'd1,      32'h5,        16'd11,    1'b0, 0, ST_LOADED,  0, 0},
    '{POL_BEST,  CMD_LOAD,    17'd1,      32'h6,        16'd12,    1'b0, 0, ST_LOADED,  0, 0},
    '{POL_BEST,  CMD_ALLOC,   17'd2,      32'h7,        16'd0,     1'b0, 0, ST_ALLOC,   0, 0},
    '{POL_BEST,  CMD_ALLOC,   17'd1,      32'h8,        16'd0,     1'b0, 0, ST_ALLOC,   0, 0},
    '{POL_WORST, CMD_COMPACT, 17'd1,      32'h9,        16'd0,     1'b0, 0, ST_ALLOC,   0, 0},
    '{POL_WORST, CMD_LOAD,    17'd1,      32'ha,        16'd100,   1'b0, 0, ST_LOADED,  0, 0},
    '{POL_WORST, CMD_LOAD,    17'd1,      32'hb,        16'd40000, 1'b0, 0, ST_LOADED,  0, 0},
    '{POL_WORST, CMD_ALLOC,   17'd1,      32'hc,        16'd0,     1'b0, 0, ST_ALLOC,   0, 0},
    '{POL_NEXT,  CMD_LOAD,    17'd1,      32'hd,        16'd200,   1'b0, 0, ST_LOADED,  0, 0},
    '{POL_NEXT,  CMD_LOAD,    17'd1,      32'he,        16'd201,   1'b0, 0, ST_LOADED,  0, 0},
    '{POL_NEXT,  CMD_ALLOC,   17'd1,      32'hf,        16'd0,     1'b0, 0, ST_ALLOC,   0, 0},
    '{POL_NEXT,  CMD_ALLOC,   17'd1,      32'h10,       16'd0,     1'b0, 0, ST_ALLOC,   0, 0},
    '{POL_NEXT,  CMD_ALLOC,   17'd1,      32'h11,       16'd0,     1'b0, 0, ST_ALLOC,   0, 0},
    '{POL_NEXT,  CMD_COMPACT, 17'd1,      32'h12,       16'd0,     1'b0, 0, ST_ALLOC,   0, 0},
    '{POL_FIRST, CMD_ALLOC,   17'd65536,  32'h13,       16'd0,     1'b0, 0, ST_ALLOC,   0, 0},
    '{POL_FIRST, CMD_LOAD,    17'd1,      32'h14,       16'd65535, 1'b1, 0, ST_LOADED,  0, 0}
  };

  policy_t phase_pol [6] = '{POL_FIRST, POL_NEXT, POL_BEST, POL_WORST, POL_NEXT, POL_FIRST};

  initial begin
    int left;
    req_ch.valid = 0; req_ch.command = CMD_LOAD; req_ch.request_size = '0;
    req_ch.request_tag = '0; req_ch.unit_index = '0; req_ch.unit_used = 0;
    for (int u = 0; u < UNITS; u++) occ_map[u] = 0;
    next_pos = 0; fails_seen = 0; cur_policy = POL_FIRST;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    @(negedge clk);

    foreach (directed[i]) begin
      if (directed[i].pol != cur_policy || i == 0) set_policy(directed[i].pol);
      send_item(directed[i]);
    end

    for (int ph = 0; ph < 6; ph++) begin
      set_policy(phase_pol[ph]);
      left = 45;
      while (left > 0) begin
        repeat ($urandom_range(1, 8)) begin
          if (left > 0) begin
            if (ph == 2 && left == 20) hold_off_req = 1;
            if (ph == 4 && left == 20) drain();
            send_item(random_row());
            left--;
          end
        end
        if ($urandom_range(0, 2) != 0) begin
          req_ch.valid <= 0;
          repeat ($urandom_range(1, 6)) @(negedge clk);
        end
      end
    end

    drain();
    repeat (20) @(posedge clk);
    $display("covered all four fit policies: %0d allocated, %0d failed, %0d compacts,",
             n_alloc, n_fail, n_compact);
    $display("%0d loads or no-ops, with bursty requests and response stalls", n_load);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #(64'd1_000_000_000);
    $display("timeout");
    $display("FAIL");
    $finish;
  end

endmodule
